// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent property on i_clk, quiet while reset is held
`define GFVV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define GFVV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/gfvv_pkg.sv
package gfvv_pkg;

    // default geometry
    localparam int COORD_BITS_DEF = 12;
    localparam int OUT_BITS_DEF   = 16;

    // register file
    localparam int CENTER_W   = 16;
    localparam int PEAK_W     = 16;
    localparam int ITV_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_CENTER_Z    = 3'd2,
        CFG_PEAK_VALUE  = 3'd3,
        CFG_INV_TWO_VAR = 3'd4
    } t_cfg_idx;

    localparam logic signed [CENTER_W-1:0] CENTER_RST = 16'sd0;
    localparam logic [PEAK_W-1:0]          PEAK_RST   = 16'd2560;
    localparam logic [ITV_W-1:0]           ITV_RST    = 32'd214748;

    // coordinates are integers, the centre carries four fraction bits
    localparam int COORD_FRAC = 4;

    // exponent a = d2 * itv >> 24, flushed once a reaches 32.0 in Q.16
    localparam int D2_SPLIT = 21;
    localparam int A_LSB    = 24;
    localparam int A_W      = 21;

    // x = a * log2(e), Q.16
    localparam int              LOG2E_W   = 17;
    localparam logic [LOG2E_W-1:0] LOG2E_Q16 = 17'd94548;
    localparam int XP_W   = A_W + LOG2E_W;
    localparam int X_FRAC = 16;
    localparam int X_W    = XP_W - X_FRAC;
    localparam int N_W    = X_W - X_FRAC;
    // largest integer part of x below the flush limit
    localparam logic [N_W-1:0] N_MAX = 6'd46;

    // fraction of x: table index and interpolation weight
    localparam int IDX_W = 4;
    localparam int R_W   = 12;
    localparam int TI_W  = IDX_W + 1;
    localparam int TAB_W = 17;
    localparam int DT_W  = 12;
    localparam int DR_W  = DT_W + R_W;

    // peak * mantissa and the final rounding shift
    localparam int PM_W       = PEAK_W + TAB_W;
    localparam int TAB_FRAC   = 16;
    localparam int RND_SHIFT  = TAB_FRAC - 1;
    localparam int RES_W      = PM_W - RND_SHIFT;
    localparam int SH_W       = N_W + 1;

    typedef struct packed {
        logic vld;
        logic flush;
    } t_pipe_ctl;

    typedef struct packed {
        logic           vld;
        logic           flush;
        logic [N_W-1:0] n;
    } t_exp_ctl;

    // magnitude width of centre - coord*16
    function automatic int mag_bits(input int coord_bits);
        int m;
        m = (CENTER_W - 1 > coord_bits + 3) ? CENTER_W - 1 : coord_bits + 3;
        return m + 1;
    endfunction

    // squared distance width, three squares summed
    function automatic int d2_bits(input int coord_bits);
        return 2 * mag_bits(coord_bits) + 2;
    endfunction

    // 2^(-i/16) in Q.16
    function automatic logic [TAB_W-1:0] pow2_tab(input logic [TI_W-1:0] idx);
        logic [TAB_W-1:0] v;
        unique case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

// File: src/gfvv_if.sv
// voxel coordinate request
interface gfvv_in_if import gfvv_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;

    modport source(output valid, output coord_x, output coord_y, output coord_z,
                   input ready);
    modport sink(input valid, input coord_x, input coord_y, input coord_z,
                 output ready);
endinterface

// field value request
interface gfvv_out_if import gfvv_pkg::*; #(
    parameter int OUT_BITS = OUT_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] field_value;

    modport source(output valid, output field_value, input ready);
    modport sink(input valid, input field_value, output ready);
endinterface

// register write request
interface gfvv_cfg_if import gfvv_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, output idx, output data, input ready);
    modport sink(input valid, input idx, input data, output ready);
endinterface

// File: src/gfvv_dist.sv
`include "assert_macros.svh"

module gfvv_dist import gfvv_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_ce,
    input  logic                         i_vld,
    input  logic signed [COORD_BITS-1:0] i_coord [3],
    input  logic signed [CENTER_W-1:0]   i_center [3],
    output logic                         o_vld,
    output logic [d2_bits(COORD_BITS)-1:0] o_d2
);

    localparam int MAG_W  = mag_bits(COORD_BITS);
    localparam int DIFF_W = MAG_W + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int D2_W   = d2_bits(COORD_BITS);

    logic [2:0]               r_vld;
    logic signed [DIFF_W-1:0] diff [3];
    logic [MAG_W-1:0]         n_mag [3];
    logic [MAG_W-1:0]         r_mag [3];
    logic [SQ_W-1:0]          n_sq [3];
    logic [SQ_W-1:0]          r_sq [3];
    logic [D2_W-1:0]          n_d2;
    logic [D2_W-1:0]          r_d2;

    // per-axis offset in Q.4 and its magnitude
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k]  = DIFF_W'(i_center[k]) - (DIFF_W'(i_coord[k]) <<< COORD_FRAC);
            n_mag[k] = diff[k][DIFF_W-1] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);
            n_sq[k]  = SQ_W'(r_mag[k]) * SQ_W'(r_mag[k]);
        end
        n_d2 = D2_W'(r_sq[0]) + D2_W'(r_sq[1]) + D2_W'(r_sq[2]);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    // magnitude, square, sum
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_mag <= n_mag;
            r_sq  <= n_sq;
            r_d2  <= n_d2;
        end
    end

    assign o_vld = r_vld[2];
    assign o_d2  = r_d2;

    // a stalled pipe keeps its occupancy
    `GFVV_ASSERT_NEXT(a_dist_hold, !i_ce, $stable(r_vld), "distance pipe moved while stalled")

endmodule

// File: src/gfvv_exp.sv
`include "assert_macros.svh"

module gfvv_exp import gfvv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  t_pipe_ctl         i_ctl,
    input  logic [A_W-1:0]    i_a,
    input  logic [PEAK_W-1:0] i_peak,
    output t_exp_ctl          o_ctl,
    output logic [PM_W-1:0]   o_pm
);

    logic [XP_W-1:0]  xp;
    t_pipe_ctl        r6_ctl;
    logic [X_W-1:0]   r6_x;

    logic [IDX_W-1:0] idx;
    logic [R_W-1:0]   rr;
    logic [TAB_W-1:0] t0;
    logic [TAB_W-1:0] t1;
    logic [DT_W-1:0]  dt;
    logic [DR_W-1:0]  dr;
    t_exp_ctl         n7_ctl;
    t_exp_ctl         r7_ctl;
    logic [TAB_W-1:0] r7_t0;
    logic [DR_W-1:0]  r7_dr;

    logic [TAB_W-1:0] m;
    logic [PM_W-1:0]  pm;
    t_exp_ctl         r8_ctl;
    logic [PM_W-1:0]  r8_pm;

    // exponent to base 2
    assign xp = XP_W'(i_a) * XP_W'(LOG2E_Q16);

    // table pair and interpolation step
    always_comb begin
        idx          = r6_x[X_FRAC-1 -: IDX_W];
        rr           = r6_x[R_W-1:0];
        t0           = pow2_tab({1'b0, idx});
        t1           = pow2_tab(TI_W'(idx) + TI_W'(1));
        dt           = DT_W'(t0 - t1);
        dr           = DR_W'(dt) * DR_W'(rr);
        n7_ctl.vld   = r6_ctl.vld;
        n7_ctl.flush = r6_ctl.flush;
        n7_ctl.n     = r6_x[X_W-1 -: N_W];
    end

    // mantissa times peak
    assign m  = r7_t0 - TAB_W'(r7_dr >> R_W);
    assign pm = PM_W'(i_peak) * PM_W'(m);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_ctl <= '0;
            r7_ctl <= '0;
            r8_ctl <= '0;
        end else if (i_ce) begin
            r6_ctl <= i_ctl;
            r7_ctl <= n7_ctl;
            r8_ctl <= r7_ctl;
        end
    end

    // data
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r6_x  <= xp[XP_W-1:X_FRAC];
            r7_t0 <= t0;
            r7_dr <= dr;
            r8_pm <= pm;
        end
    end

    assign o_ctl = r8_ctl;
    assign o_pm  = r8_pm;

    // below the flush limit the shift count stays small
    `GFVV_ASSERT(a_exp_range, (r8_ctl.vld && !r8_ctl.flush) |-> (r8_ctl.n <= N_MAX), "shift count above flush limit")

endmodule

// File: src/gaussian_field_voxel_value.sv
// Gaussian field voxel value. Each request carries one voxel coordinate and returns
// peak_value * exp(-d2 * inv_two_variance) in unsigned Q8.8, where d2 is the squared
// distance to the Q12.4 centre; exponents of 32.0 and above give 0 and the result
// saturates at the top of the output width. The block takes one request per clock while the
// output is not held and has nine register stages (offset, square, sum, two-part scale multiply,
// exponent recombine, log2(e) multiply, table interpolation, peak multiply, rounding shift).
// The pipe stalls as a whole only while a finished value waits at the output. Registers are
// written by index on the configuration channel, which is always ready; write them while no
// request is in flight.
`include "assert_macros.svh"

module gaussian_field_voxel_value import gfvv_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int OUT_BITS   = OUT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gfvv_in_if.sink     i_in,
    gfvv_out_if.source  o_out,
    gfvv_cfg_if.sink    i_cfg
);

    localparam int D2_W   = d2_bits(COORD_BITS);
    localparam int DH_W   = D2_W - D2_SPLIT;
    localparam int PL_W   = D2_SPLIT + ITV_W;
    localparam int PH_W   = DH_W + ITV_W;
    localparam int PROD_W = D2_W + ITV_W;
    localparam int CMP_W  = (OUT_BITS > RES_W) ? OUT_BITS : RES_W;

    // configuration registers
    logic signed [CENTER_W-1:0] r_center_x;
    logic signed [CENTER_W-1:0] r_center_y;
    logic signed [CENTER_W-1:0] r_center_z;
    logic [PEAK_W-1:0]          r_peak;
    logic [ITV_W-1:0]           r_itv;

    logic                         adv;
    logic signed [COORD_BITS-1:0] coord [3];
    logic signed [CENTER_W-1:0]   center [3];
    logic                         d2_vld;
    logic [D2_W-1:0]              d2;

    logic              r4_vld;
    logic [PL_W-1:0]   r4_pl;
    logic [PH_W-1:0]   r4_ph;
    logic [PROD_W-1:0] prod;
    t_pipe_ctl         n5_ctl;
    t_pipe_ctl         r5_ctl;
    logic [A_W-1:0]    r5_a;

    t_exp_ctl          exp_ctl;
    logic [PM_W-1:0]   exp_pm;

    logic [SH_W-1:0]     shamt;
    logic [PM_W-1:0]     tq;
    logic [RES_W:0]      rnd;
    logic [CMP_W-1:0]    res_ext;
    logic                sat;
    logic [OUT_BITS-1:0] n_out_val;
    logic [OUT_BITS-1:0] r_out_val;
    logic                r_out_vld;

    // register writes, unknown indexes dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= CENTER_RST;
            r_center_y <= CENTER_RST;
            r_center_z <= CENTER_RST;
            r_peak     <= PEAK_RST;
            r_itv      <= ITV_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.idx))
                CFG_CENTER_X:    r_center_x <= signed'(i_cfg.data[CENTER_W-1:0]);
                CFG_CENTER_Y:    r_center_y <= signed'(i_cfg.data[CENTER_W-1:0]);
                CFG_CENTER_Z:    r_center_z <= signed'(i_cfg.data[CENTER_W-1:0]);
                CFG_PEAK_VALUE:  r_peak     <= i_cfg.data[PEAK_W-1:0];
                CFG_INV_TWO_VAR: r_itv      <= i_cfg.data[ITV_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipe advances unless the output holds an untaken value
    assign adv        = !r_out_vld || o_out.ready;
    assign i_in.ready = adv;

    assign coord[0]  = i_in.coord_x;
    assign coord[1]  = i_in.coord_y;
    assign coord[2]  = i_in.coord_z;
    assign center[0] = r_center_x;
    assign center[1] = r_center_y;
    assign center[2] = r_center_z;

    // squared distance
    gfvv_dist #(
        .COORD_BITS(COORD_BITS)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (adv),
        .i_vld    (i_in.valid),
        .i_coord  (coord),
        .i_center (center),
        .o_vld    (d2_vld),
        .o_d2     (d2)
    );

    // exponent: d2 * itv >> 24, recombined from two partial products
    assign prod         = (PROD_W'(r4_ph) << D2_SPLIT) + PROD_W'(r4_pl);
    assign n5_ctl.vld   = r4_vld;
    assign n5_ctl.flush = |prod[PROD_W-1:A_LSB+A_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_ctl <= '0;
        end else if (adv) begin
            r4_vld <= d2_vld;
            r5_ctl <= n5_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_pl <= PL_W'(d2[D2_SPLIT-1:0]) * PL_W'(r_itv);
            r4_ph <= PH_W'(d2[D2_W-1:D2_SPLIT]) * PH_W'(r_itv);
            r5_a  <= prod[A_LSB +: A_W];
        end
    end

    // 2^-x mantissa times peak
    gfvv_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (adv),
        .i_ctl   (r5_ctl),
        .i_a     (r5_a),
        .i_peak  (r_peak),
        .o_ctl   (exp_ctl),
        .o_pm    (exp_pm)
    );

    // round half up at 16 + n, then saturate
    always_comb begin
        shamt   = SH_W'(exp_ctl.n) + SH_W'(RND_SHIFT);
        tq      = exp_pm >> shamt;
        rnd     = (RES_W + 1)'(tq[RES_W-1:0]) + (RES_W + 1)'(1);
        res_ext = CMP_W'(rnd[RES_W:1]);
        sat     = (res_ext >> OUT_BITS) != '0;
        if (exp_ctl.flush) begin
            n_out_val = '0;
        end else if (sat) begin
            n_out_val = '1;
        end else begin
            n_out_val = OUT_BITS'(res_ext);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= exp_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_val <= n_out_val;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.field_value = r_out_val;

    // a flushed request leaves as zero
    `GFVV_ASSERT_NEXT(a_flush_zero, adv && exp_ctl.vld && exp_ctl.flush, o_out.valid && (o_out.field_value == '0), "flushed request not zero")
    // a finished request always reaches the output register
    `GFVV_ASSERT_NEXT(a_out_fill, adv && exp_ctl.vld, o_out.valid, "finished request lost")

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import gfvv_pkg::*;

    localparam int    COORD_W          = COORD_BITS_DEF;
    localparam int    FIELD_W          = OUT_BITS_DEF;
    localparam int    SINK_HOLD_CYCLES = 80;
    localparam int    DRAIN_CYCLES     = 20;
    localparam longint TIMEOUT_NS      = 2_000_000;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    // exponent flush point, 32.0 in Q.16
    localparam longint unsigned EXP_FLUSH_Q16 = 64'd32 << 16;
    localparam longint unsigned LOG2E_FIX     = 64'd94548;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_voxel;

    typedef struct packed {
        t_voxel             voxel;
        logic [FIELD_W-1:0] value;
    } t_field_expect;

    logic i_clk;
    logic i_rst_n;

    gfvv_in_if  #(.COORD_BITS(COORD_W)) voxel_if ();
    gfvv_out_if #(.OUT_BITS(FIELD_W))   field_if ();
    gfvv_cfg_if                         cfg_if ();

    gaussian_field_voxel_value #(
        .COORD_BITS(COORD_W),
        .OUT_BITS  (FIELD_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (voxel_if),
        .o_out  (field_if),
        .i_cfg  (cfg_if)
    );

    // shadow copy of the register file
    logic signed [CENTER_W-1:0] gauss_cx;
    logic signed [CENTER_W-1:0] gauss_cy;
    logic signed [CENTER_W-1:0] gauss_cz;
    logic [PEAK_W-1:0]          gauss_peak;
    logic [ITV_W-1:0]           gauss_itv;

    t_voxel        voxel_queue[$];
    t_field_expect expected_field[$];

    int src_idle_pct;
    int sink_idle_pct;
    int mismatches;
    int hold_left;
    bit hold_req;
    bit hold_taken;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("testbench: FAIL");
        $finish;
    end

    // 2^(-k/16) in Q.16
    function automatic longint unsigned exp2_neg_frac(input int k);
        case (k)
            0:       return 65536;
            1:       return 62757;
            2:       return 60097;
            3:       return 57549;
            4:       return 55109;
            5:       return 52773;
            6:       return 50535;
            7:       return 48393;
            8:       return 46341;
            9:       return 44376;
            10:      return 42495;
            11:      return 40693;
            12:      return 38968;
            13:      return 37316;
            14:      return 35734;
            15:      return 34219;
            default: return 32768;
        endcase
    endfunction

    function automatic longint unsigned axis_sq(input logic signed [CENTER_W-1:0] c,
                                                input logic [COORD_W-1:0] coord);
        longint d;
        d = longint'(c) - longint'($signed(coord)) * 16;
        return longint'(d * d);
    endfunction

    // gaussian value at one voxel under the shadow registers
    function automatic logic [FIELD_W-1:0] gauss_at_voxel(input t_voxel v);
        longint unsigned d2, ph, pl, expo, xq, r, t0, t1, mant, res;
        int unsigned     n, ti, s;
        d2   = axis_sq(gauss_cx, v.x) + axis_sq(gauss_cy, v.y) + axis_sq(gauss_cz, v.z);
        ph   = d2 * longint'(gauss_itv >> 16);
        pl   = d2 * longint'(gauss_itv & 32'h0000_FFFF);
        expo = (ph >> 8) + ((((ph & 64'hFF) << 16) + pl) >> 24);
        res  = 0;
        if (expo < EXP_FLUSH_Q16) begin
            // base-2 exponent: integer part shifts, fraction interpolates
            xq   = (expo * LOG2E_FIX) >> 16;
            n    = int'(xq >> 16);
            ti   = int'((xq >> 12) & 64'hF);
            r    = xq & 64'hFFF;
            t0   = exp2_neg_frac(ti);
            t1   = exp2_neg_frac(ti + 1);
            mant = t0 - (((t0 - t1) * r) >> 12);
            s    = 16 + n;
            if (s < 63)
                res = (longint'(gauss_peak) * mant + (64'd1 << (s - 1))) >> s;
        end
        if (res > ((64'd1 << FIELD_W) - 1))
            res = (64'd1 << FIELD_W) - 1;
        return res[FIELD_W-1:0];
    endfunction

    // request driver
    always @(posedge i_clk) begin : voxel_driver
        t_voxel sent;
        t_voxel nxt;
        if (!i_rst_n) begin
            voxel_if.valid <= 1'b0;
        end else begin
            if (voxel_if.valid && voxel_if.ready) begin
                sent = '{voxel_if.coord_x, voxel_if.coord_y, voxel_if.coord_z};
                expected_field.push_back('{sent, gauss_at_voxel(sent)});
            end
            if (!voxel_if.valid || voxel_if.ready) begin
                if (voxel_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = voxel_queue.pop_front();
                    voxel_if.valid   <= 1'b1;
                    voxel_if.coord_x <= nxt.x;
                    voxel_if.coord_y <= nxt.y;
                    voxel_if.coord_z <= nxt.z;
                end else begin
                    voxel_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge i_clk) begin : field_monitor
        t_field_expect want;
        if (!i_rst_n) begin
            field_if.ready <= 1'b0;
        end else begin
            if (field_if.valid && field_if.ready) begin
                if (expected_field.size() == 0) begin
                    $display("%0t: field_value with no request pending: expected none, got %0d",
                             $time, field_if.field_value);
                    mismatches++;
                end else begin
                    want = expected_field.pop_front();
                    if (field_if.field_value !== want.value) begin
                        $display("%0t: field_value at voxel (%0d,%0d,%0d): expected %0d, got %0d",
                                 $time, $signed(want.voxel.x), $signed(want.voxel.y),
                                 $signed(want.voxel.z), want.value, field_if.field_value);
                        mismatches++;
                    end
                end
            end
            // one long hold-off so the pipe fills and stalls its input
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = SINK_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                field_if.ready <= 1'b0;
            end else begin
                field_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.idx   <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_CENTER_X:    gauss_cx   = data[CENTER_W-1:0];
            CFG_CENTER_Y:    gauss_cy   = data[CENTER_W-1:0];
            CFG_CENTER_Z:    gauss_cz   = data[CENTER_W-1:0];
            CFG_PEAK_VALUE:  gauss_peak = data[PEAK_W-1:0];
            CFG_INV_TWO_VAR: gauss_itv  = data[ITV_W-1:0];
            default: ;
        endcase
    endtask

    // wait until no request is queued, offered or in flight
    task automatic wait_pipe_empty();
        do @(negedge i_clk);
        while (voxel_queue.size() != 0 || voxel_if.valid || expected_field.size() != 0);
    endtask

    task automatic add_voxel(input int x, input int y, input int z);
        logic [31:0] ux, uy, uz;
        ux = x;
        uy = y;
        uz = z;
        voxel_queue.push_back('{ux[COORD_W-1:0], uy[COORD_W-1:0], uz[COORD_W-1:0]});
    endtask

    // coordinate scattered around one centre axis, wraps at the coordinate width
    function automatic int near_axis(input logic signed [CENTER_W-1:0] c, input int spread);
        int b;
        b = int'(c);
        b = b >>> 4;
        b = b + int'($urandom_range(2 * spread)) - spread;
        return b;
    endfunction

    task automatic add_random_voxels(input int count);
        int spread;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 15) begin
                add_voxel($urandom(), $urandom(), $urandom());
            end else begin
                case ($urandom_range(3))
                    0:       spread = 2;
                    1:       spread = 16;
                    2:       spread = 128;
                    default: spread = 1024;
                endcase
                add_voxel(near_axis(gauss_cx, spread), near_axis(gauss_cy, spread),
                          near_axis(gauss_cz, spread));
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n          = 1'b0;
        voxel_if.valid   = 1'b0;
        voxel_if.coord_x = '0;
        voxel_if.coord_y = '0;
        voxel_if.coord_z = '0;
        field_if.ready   = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.idx       = '0;
        cfg_if.data      = '0;
        gauss_cx         = CENTER_RST;
        gauss_cy         = CENTER_RST;
        gauss_cz         = CENTER_RST;
        gauss_peak       = PEAK_RST;
        gauss_itv        = ITV_RST;
        mismatches       = 0;
        hold_left        = 0;
        hold_req         = 1'b0;
        hold_taken       = 1'b0;
        src_idle_pct     = 14;
        sink_idle_pct    = 66;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: centre, far corners, axis offsets
        @(negedge i_clk);
        add_voxel(0, 0, 0);
        add_voxel(-2048, -2048, -2048);
        add_voxel(2047, 2047, 2047);
        add_voxel(2047, -2048, 0);
        add_voxel(1, 0, 0);
        add_voxel(-1, -1, -1);
        add_voxel(100, 0, 0);
        add_voxel(0, -200, 0);
        add_voxel(0, 0, 300);
        add_voxel(150, 150, 150);
        add_random_voxels(200);
        wait_pipe_empty();

        // centre at the extremes, steepest falloff, full peak
        write_reg(CFG_CENTER_X, 32'hA5A5_8000);
        write_reg(CFG_CENTER_Y, 32'h0000_7FFF);
        write_reg(CFG_CENTER_Z, 32'h5A5A_8000);
        write_reg(CFG_PEAK_VALUE, 32'hFFFF_FFFF);
        write_reg(CFG_INV_TWO_VAR, 32'hFFFF_FFFF);
        @(negedge i_clk);
        add_voxel(-2048, 2047, -2048);
        add_voxel(-2047, 2046, -2047);
        add_voxel(2047, -2048, 2047);
        add_voxel(0, 0, 0);
        add_random_voxels(150);
        wait_pipe_empty();

        // zero peak, zero exponent; spare indexes must leave registers alone
        write_reg(CFG_PEAK_VALUE, 32'h0000_0000);
        write_reg(CFG_INV_TWO_VAR, 32'h0000_0000);
        write_reg(CFG_CENTER_X, 32'h0000_0123);
        write_reg(CFG_CENTER_Y, 32'h0000_FEDC);
        write_reg(CFG_CENTER_Z, 32'h0000_0008);
        for (int k = CFG_SPARE_FIRST; k <= CFG_SPARE_LAST; k++)
            write_reg(CFG_IDX_W'(k), 32'hFFFF_FFFF);
        @(negedge i_clk);
        add_voxel(5, -7, 100);
        add_voxel(-2048, 2047, 0);
        add_random_voxels(50);
        wait_pipe_empty();

        // flush boundary: exponent is d2 / 128, limit reached at distance 64
        src_idle_pct  = 66;
        sink_idle_pct = 14;
        write_reg(CFG_CENTER_X, 32'h0000_0000);
        write_reg(CFG_CENTER_Y, 32'h0000_0000);
        write_reg(CFG_CENTER_Z, 32'h0000_0000);
        write_reg(CFG_PEAK_VALUE, 32'h0000_FFFF);
        write_reg(CFG_INV_TWO_VAR, 32'h0200_0000);
        @(negedge i_clk);
        add_voxel(64, 0, 0);
        add_voxel(63, 8, 0);
        add_voxel(0, -64, 0);
        add_voxel(1, 0, 0);
        add_voxel(0, 0, 0);
        add_random_voxels(100);
        wait_pipe_empty();

        // flat field at full scale
        write_reg(CFG_INV_TWO_VAR, 32'h0000_0000);
        write_reg(CFG_CENTER_X, 32'h0000_7FFF);
        @(negedge i_clk);
        add_voxel(0, 0, 0);
        add_voxel(2047, -2048, 5);
        add_random_voxels(50);
        wait_pipe_empty();

        // random register sets, no idling; long receiver hold on the first
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        for (int round = 0; round < 4; round++) begin
            write_reg(CFG_CENTER_X, $urandom());
            write_reg(CFG_CENTER_Y, $urandom());
            write_reg(CFG_CENTER_Z, $urandom());
            write_reg(CFG_PEAK_VALUE, $urandom());
            write_reg(CFG_INV_TWO_VAR, $urandom() >> $urandom_range(31));
            @(negedge i_clk);
            add_random_voxels(75);
            if (round == 0)
                hold_req = 1'b1;
            wait_pipe_empty();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
